// ===== design/sync_framed_packet_receiver_macros.svh =====
// ----------------------------------------------------------------------------
// sync framed packet receiver assertion macros
// concurrent assertion wrappers used by the top-level receiver module
// ----------------------------------------------------------------------------
`ifndef SYNC_FRAMED_PACKET_RECEIVER_MACROS_SVH
`define SYNC_FRAMED_PACKET_RECEIVER_MACROS_SVH

`ifndef NO_ASSERTIONS

// same-cycle implication
`define SFPR_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define SFPR_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`else

`define SFPR_ASSERT_NOW(label, clk, rst, ante, cons, msg)
`define SFPR_ASSERT_NEXT(label, clk, rst, ante, cons, msg)

`endif

`endif

// ===== design/sfpr_pkg.sv =====
// ----------------------------------------------------------------------------
// sfpr_pkg
// shared types and constants of the sync framed packet receiver
// ----------------------------------------------------------------------------
package sfpr_pkg;

   localparam int unsigned BYTE_W      = 8;
   localparam int unsigned LEN_W       = 16;
   localparam int unsigned IDX_W       = 9;
   localparam int unsigned KIND_W      = 3;
   localparam int unsigned MAX_PAYLOAD = 512;
   localparam int unsigned RSP_DATA_W  = 56;

   localparam logic [BYTE_W-1:0] SYNC_FIRST_RST  = 8'd83;
   localparam logic [BYTE_W-1:0] SYNC_SECOND_RST = 8'd89;
   localparam logic [BYTE_W-1:0] TAIL_FIRST_RST  = 8'd84;
   localparam logic [BYTE_W-1:0] TAIL_SECOND_RST = 8'd67;

   typedef enum logic [1:0] {
      REG_SYNC_FIRST,
      REG_SYNC_SECOND,
      REG_TAIL_FIRST,
      REG_TAIL_SECOND
   } reg_index_type;

   typedef enum logic [KIND_W-1:0] {
      KIND_PAYLOAD,
      KIND_GOOD,
      KIND_GOOD_OVERSIZE,
      KIND_CSUM_ERR,
      KIND_TAIL_ERR
   } kind_type;

   typedef struct packed {
      logic [BYTE_W-1:0] sync_first;
      logic [BYTE_W-1:0] sync_second;
      logic [BYTE_W-1:0] tail_first;
      logic [BYTE_W-1:0] tail_second;
   } cfg_type;

   typedef struct packed {
      logic              valid;
      kind_type          kind;
      logic [BYTE_W-1:0] ctrl;
      logic [BYTE_W-1:0] cmd;
      logic [LEN_W-1:0]  length;
      logic [BYTE_W-1:0] data;
      logic [IDX_W-1:0]  index;
   } result_type;

endpackage

// ===== design/sfpr_parser.sv =====
// ----------------------------------------------------------------------------
// sfpr_parser
// frame state machine: header capture, payload count, checksum and trailer
// ----------------------------------------------------------------------------
module sfpr_parser
   import sfpr_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              step,
   input  logic [BYTE_W-1:0] rx_byte,
   input  cfg_type           cfg,
   output result_type        result
);

   typedef enum logic [3:0] {
      ST_SYNC1,
      ST_SYNC2,
      ST_CTRL,
      ST_CMD,
      ST_LEN_HI,
      ST_LEN_LO,
      ST_PAYLOAD,
      ST_CSUM,
      ST_TAIL1,
      ST_TAIL2
   } phase_type;

   phase_type         phase_ff, phase_in;
   logic [BYTE_W-1:0] ctrl_ff, ctrl_in;
   logic [BYTE_W-1:0] cmd_ff, cmd_in;
   logic [LEN_W-1:0]  length_ff, length_in;
   logic [LEN_W-1:0]  count_ff, count_in;
   logic [BYTE_W-1:0] sum_ff, sum_in;
   logic              oversize_ff, oversize_in;

   logic [BYTE_W-1:0] sum_add;
   logic [LEN_W-1:0]  count_inc;
   logic [LEN_W-1:0]  length_full;
   logic              is_sync1;

   assign sum_add     = sum_ff + rx_byte;
   assign count_inc   = count_ff + 16'd1;
   assign length_full = {length_ff[LEN_W-1:BYTE_W], rx_byte};
   assign is_sync1    = (rx_byte == cfg.sync_first);

   always_comb begin
      phase_in    = phase_ff;
      ctrl_in     = ctrl_ff;
      cmd_in      = cmd_ff;
      length_in   = length_ff;
      count_in    = count_ff;
      sum_in      = sum_ff;
      oversize_in = oversize_ff;

      result.valid  = 1'b0;
      result.kind   = KIND_PAYLOAD;
      result.ctrl   = ctrl_ff;
      result.cmd    = cmd_ff;
      result.length = length_ff;
      result.data   = '0;
      result.index  = '0;

      unique case (phase_ff)
         ST_SYNC2: begin
            if (rx_byte == cfg.sync_second) begin
               sum_in   = sum_add;
               phase_in = ST_CTRL;
            end else if (is_sync1) begin
               sum_in   = rx_byte;
               phase_in = ST_SYNC2;
            end else begin
               phase_in = ST_SYNC1;
            end
         end
         ST_CTRL: begin
            ctrl_in  = rx_byte;
            sum_in   = sum_add;
            phase_in = ST_CMD;
         end
         ST_CMD: begin
            cmd_in   = rx_byte;
            sum_in   = sum_add;
            phase_in = ST_LEN_HI;
         end
         ST_LEN_HI: begin
            length_in = {rx_byte, {BYTE_W{1'b0}}};
            sum_in    = sum_add;
            phase_in  = ST_LEN_LO;
         end
         ST_LEN_LO: begin
            length_in   = length_full;
            sum_in      = sum_add;
            count_in    = '0;
            oversize_in = (length_full > LEN_W'(MAX_PAYLOAD));
            phase_in    = (length_full == '0) ? ST_CSUM : ST_PAYLOAD;
         end
         ST_PAYLOAD: begin
            if (!oversize_ff) begin
               result.valid = 1'b1;
               result.kind  = KIND_PAYLOAD;
               result.data  = rx_byte;
               result.index = count_ff[IDX_W-1:0];
            end
            count_in = count_inc;
            sum_in   = sum_add;
            if (count_inc >= length_ff) begin
               phase_in = ST_CSUM;
            end
         end
         ST_CSUM: begin
            if (rx_byte == sum_ff) begin
               phase_in = ST_TAIL1;
            end else begin
               result.valid = 1'b1;
               result.kind  = KIND_CSUM_ERR;
               if (is_sync1) begin
                  sum_in   = rx_byte;
                  phase_in = ST_SYNC2;
               end else begin
                  phase_in = ST_SYNC1;
               end
            end
         end
         ST_TAIL1: begin
            if (rx_byte == cfg.tail_first) begin
               phase_in = ST_TAIL2;
            end else begin
               result.valid = 1'b1;
               result.kind  = KIND_TAIL_ERR;
               if (is_sync1) begin
                  sum_in   = rx_byte;
                  phase_in = ST_SYNC2;
               end else begin
                  phase_in = ST_SYNC1;
               end
            end
         end
         ST_TAIL2: begin
            result.valid = 1'b1;
            oversize_in  = 1'b0;
            if (rx_byte == cfg.tail_second) begin
               result.kind = oversize_ff ? KIND_GOOD_OVERSIZE : KIND_GOOD;
               phase_in    = ST_SYNC1;
            end else begin
               result.kind = KIND_TAIL_ERR;
               if (is_sync1) begin
                  sum_in   = rx_byte;
                  phase_in = ST_SYNC2;
               end else begin
                  phase_in = ST_SYNC1;
               end
            end
         end
         default: begin
            if (is_sync1) begin
               sum_in   = rx_byte;
               phase_in = ST_SYNC2;
            end else begin
               phase_in = ST_SYNC1;
            end
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff    <= ST_SYNC1;
         ctrl_ff     <= '0;
         cmd_ff      <= '0;
         length_ff   <= '0;
         count_ff    <= '0;
         sum_ff      <= '0;
         oversize_ff <= 1'b0;
      end else if (step) begin
         phase_ff    <= phase_in;
         ctrl_ff     <= ctrl_in;
         cmd_ff      <= cmd_in;
         length_ff   <= length_in;
         count_ff    <= count_in;
         sum_ff      <= sum_in;
         oversize_ff <= oversize_in;
      end
   end

endmodule

// ===== design/sync_framed_packet_receiver.sv =====
// ----------------------------------------------------------------------------
// sync_framed_packet_receiver
// deframes sync/header/payload/checksum/trailer packets from a byte stream
// ----------------------------------------------------------------------------
// channel   direction  tdata / fields                        tuser
// req       in         rx_byte [7:0]                         -
// rsp       out        see rsp_tdata                         result_kind [2:0]
// csr       in         csr_index selects register, csr_data  -
//
// one byte per cycle; each transfer is parsed in the cycle it is accepted
// and its result sits in the output register the next cycle
// synchronous reset restores the default sync and trailer bytes
// the input stalls only while a result is held by rsp_tready low
// ----------------------------------------------------------------------------
`include "sync_framed_packet_receiver_macros.svh"

module sync_framed_packet_receiver
   import sfpr_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,

   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [BYTE_W-1:0]     req_tdata,   // rx_byte [7:0]

   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   // frame_ctrl [7:0], frame_cmd [15:8], payload_length [31:16],
   // payload_byte [39:32], payload_index [48:40], zero [55:49]
   output logic [RSP_DATA_W-1:0] rsp_tdata,
   output logic [KIND_W-1:0]     rsp_tuser,   // result_kind [2:0]

   input  logic                  csr_valid,
   output logic                  csr_ready,
   input  reg_index_type         csr_index,
   input  logic [BYTE_W-1:0]     csr_data
);

   cfg_type    cfg_ff;
   result_type res;
   result_type rsp_ff, rsp_in;
   logic       step;

   assign req_tready = !rsp_ff.valid || rsp_tready;
   assign step       = req_tvalid && req_tready;
   assign csr_ready  = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.sync_first  <= SYNC_FIRST_RST;
         cfg_ff.sync_second <= SYNC_SECOND_RST;
         cfg_ff.tail_first  <= TAIL_FIRST_RST;
         cfg_ff.tail_second <= TAIL_SECOND_RST;
      end else if (csr_valid) begin
         unique case (csr_index)
            REG_SYNC_FIRST:  cfg_ff.sync_first  <= csr_data;
            REG_SYNC_SECOND: cfg_ff.sync_second <= csr_data;
            REG_TAIL_FIRST:  cfg_ff.tail_first  <= csr_data;
            REG_TAIL_SECOND: cfg_ff.tail_second <= csr_data;
         endcase
      end
   end

   sfpr_parser u_parser (
      .clock   (clock),
      .reset   (reset),
      .step    (step),
      .rx_byte (req_tdata),
      .cfg     (cfg_ff),
      .result  (res)
   );

   // output register
   always_comb begin
      rsp_in = rsp_ff;
      if (step) begin
         rsp_in = res;
      end else if (rsp_tready) begin
         rsp_in.valid = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_ff.valid <= 1'b0;
      end else begin
         rsp_ff.valid <= rsp_in.valid;
      end
      rsp_ff.kind   <= rsp_in.kind;
      rsp_ff.ctrl   <= rsp_in.ctrl;
      rsp_ff.cmd    <= rsp_in.cmd;
      rsp_ff.length <= rsp_in.length;
      rsp_ff.data   <= rsp_in.data;
      rsp_ff.index  <= rsp_in.index;
   end

   assign rsp_tvalid = rsp_ff.valid;
   assign rsp_tuser  = rsp_ff.kind;
   assign rsp_tdata  = {7'd0, rsp_ff.index, rsp_ff.data, rsp_ff.length,
                        rsp_ff.cmd, rsp_ff.ctrl};

   `SFPR_ASSERT_NOW(a_stall_blocks_input, clock, reset,
      rsp_ff.valid && !rsp_tready, !req_tready, "input taken while result stalled")
   `SFPR_ASSERT_NOW(a_payload_not_oversize, clock, reset,
      rsp_ff.valid && rsp_ff.kind == KIND_PAYLOAD,
      rsp_ff.length != '0 && rsp_ff.length <= LEN_W'(MAX_PAYLOAD),
      "payload byte from empty or oversize frame")
   `SFPR_ASSERT_NOW(a_status_zero_fields, clock, reset,
      rsp_ff.valid && rsp_ff.kind != KIND_PAYLOAD,
      rsp_ff.data == '0 && rsp_ff.index == '0, "status result carries payload fields")
   `SFPR_ASSERT_NEXT(a_no_result_without_transfer, clock, reset,
      !rsp_ff.valid && !step, !rsp_ff.valid, "result appeared without input transfer")

endmodule
